// ===== hw/rtl/u2a_pkg.sv =====
// shared types, constants and functions for the unsigned integer to ascii converter
`timescale 1ns / 1ps

package u2a_pkg;

   localparam int VALUE_WIDTH = 64;

   // digit counts per radix, enough for any value of VALUE_WIDTH bits
   localparam int BIN_DIGITS = VALUE_WIDTH;
   localparam int OCT_DIGITS = (VALUE_WIDTH + 2) / 3;
   localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
   localparam int DEC_DIGITS = (VALUE_WIDTH + 2) / 3;

   // digit register holds bcd digits or left-aligned binary groups
   localparam int DIGIT_WIDTH = 4 * DEC_DIGITS;
   localparam int BIN_SHIFT = DIGIT_WIDTH - BIN_DIGITS;
   localparam int OCT_SHIFT = DIGIT_WIDTH - 3 * OCT_DIGITS;
   localparam int HEX_SHIFT = DIGIT_WIDTH - 4 * HEX_DIGITS;

   localparam int CNT_WIDTH = $clog2(VALUE_WIDTH + 1);

   localparam logic [1:0] RADIX_BIN = 2'd0;
   localparam logic [1:0] RADIX_OCT = 2'd1;
   localparam logic [1:0] RADIX_DEC = 2'd2;
   localparam logic [1:0] RADIX_HEX = 2'd3;

   localparam logic [6:0] ASCII_ZERO = 7'd48;
   localparam logic [6:0] ASCII_UPPER_A = 7'd65;

   typedef struct packed {
      logic [63:0] value;
      logic [1:0]  radix_select;
   } req_type;

   typedef struct packed {
      logic [6:0] digit_char;
      logic       last_digit;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic dabble;
      logic shift;
   } cmd_type;

   typedef struct packed {
      logic top_zero;
      logic cnt_one;
      logic dabble_done;
   } status_type;

   function automatic logic [6:0] digit_to_ascii(input logic [3:0] digit);
      logic [6:0] code;
      if (digit < 4'd10) begin
         code = ASCII_ZERO + 7'(digit);
      end else begin
         code = ASCII_UPPER_A + 7'(digit - 4'd10);
      end
      return code;
   endfunction

endpackage

// ===== hw/rtl/uint_to_ascii_radix.sv =====
// top level of the unsigned integer to ascii converter, base 2, 8, 10 or 16
`timescale 1ns / 1ps

// usage
// req channel: one transaction carries a 64-bit unsigned value and a radix
// select (0 binary, 1 octal, 2 decimal, 3 hexadecimal). req_ready is high only
// while the block is idle, so one value is converted at a time.
// rsp channel: one transaction per ascii digit, most significant first,
// uppercase hex letters, no leading zeros; zero gives a single '0'. the last
// digit of a number carries last_digit.
// sequence: the load, then for decimal 64 double dabble steps in the convert
// state, otherwise none. leading zero digits are then dropped one per cycle
// (up to 63 in binary), then rsp_valid is raised and digits go out one per
// cycle while rsp_ready is high. req_ready returns in the cycle after the
// last digit is taken.
// reset returns the block to idle with no rsp pending; the digit, value and radix registers are not reset.
// when the receiver stalls the current digit simply holds on rsp_payload.

module uint_to_ascii_radix (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  u2a_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output u2a_pkg::rsp_type rsp_payload
);
   import u2a_pkg::*;

   cmd_type    cmd;
   status_type status;

   u2a_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   u2a_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== hw/rtl/u2a_datapath.sv =====
// datapath: digit register, double dabble step, digit shift and counters
`timescale 1ns / 1ps

module u2a_datapath (
   input  logic                clock,
   input  logic                reset,
   input  u2a_pkg::req_type    req_payload,
   input  u2a_pkg::cmd_type    cmd,
   output u2a_pkg::status_type status,
   output u2a_pkg::rsp_type    rsp_payload
);
   import u2a_pkg::*;

   logic [1:0]             radix_ff, radix_in;
   logic [DIGIT_WIDTH-1:0] digits_ff, digits_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic [CNT_WIDTH-1:0]   step_ff, step_in;

   logic [VALUE_WIDTH-1:0] req_value;
   logic [DIGIT_WIDTH-1:0] value_ext;
   logic [DIGIT_WIDTH-1:0] adjusted;
   logic [3:0]             top_digit;

   assign req_value = req_payload.value[VALUE_WIDTH-1:0];
   assign value_ext = DIGIT_WIDTH'(req_value);

   // add 3 to every bcd digit of five or more before the shift
   always_comb begin
      for (int i = 0; i < DEC_DIGITS; i++) begin
         if (digits_ff[4*i +: 4] >= 4'd5) begin
            adjusted[4*i +: 4] = digits_ff[4*i +: 4] + 4'd3;
         end else begin
            adjusted[4*i +: 4] = digits_ff[4*i +: 4];
         end
      end
   end

   always_comb begin
      case (radix_ff)
         RADIX_BIN: top_digit = {3'b000, digits_ff[DIGIT_WIDTH-1]};
         RADIX_OCT: top_digit = {1'b0, digits_ff[DIGIT_WIDTH-1 -: 3]};
         default:   top_digit = digits_ff[DIGIT_WIDTH-1 -: 4];
      endcase
   end

   always_comb begin
      radix_in  = radix_ff;
      digits_in = digits_ff;
      value_in  = value_ff;
      cnt_in    = cnt_ff;
      step_in   = step_ff;
      if (cmd.load) begin
         radix_in = req_payload.radix_select;
         value_in = req_value;
         step_in  = '0;
         case (req_payload.radix_select)
            RADIX_BIN: begin
               digits_in = value_ext << BIN_SHIFT;
               cnt_in    = CNT_WIDTH'(BIN_DIGITS);
            end
            RADIX_OCT: begin
               digits_in = value_ext << OCT_SHIFT;
               cnt_in    = CNT_WIDTH'(OCT_DIGITS);
            end
            RADIX_DEC: begin
               digits_in = '0;
               cnt_in    = CNT_WIDTH'(DEC_DIGITS);
               step_in   = CNT_WIDTH'(VALUE_WIDTH);
            end
            default: begin
               digits_in = value_ext << HEX_SHIFT;
               cnt_in    = CNT_WIDTH'(HEX_DIGITS);
            end
         endcase
      end else if (cmd.dabble) begin
         digits_in = {adjusted[DIGIT_WIDTH-2:0], value_ff[VALUE_WIDTH-1]};
         value_in  = value_ff << 1;
         step_in   = step_ff - CNT_WIDTH'(1);
      end else if (cmd.shift) begin
         cnt_in = cnt_ff - CNT_WIDTH'(1);
         case (radix_ff)
            RADIX_BIN: digits_in = digits_ff << 1;
            RADIX_OCT: digits_in = digits_ff << 3;
            default:   digits_in = digits_ff << 4;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         step_ff <= step_in;
         cnt_ff  <= cnt_in;
      end
      radix_ff  <= radix_in;
      digits_ff <= digits_in;
      value_ff  <= value_in;
   end

   assign status.top_zero    = (top_digit == 4'd0);
   assign status.cnt_one     = (cnt_ff == CNT_WIDTH'(1));
   assign status.dabble_done = (step_ff == '0);

   assign rsp_payload.digit_char = digit_to_ascii(top_digit);
   assign rsp_payload.last_digit = status.cnt_one;

endmodule

// ===== hw/rtl/u2a_ctrl.sv =====
// controller: sequences load, decimal conversion, zero skip and digit output
`timescale 1ns / 1ps

module u2a_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  u2a_pkg::status_type status,
   output u2a_pkg::cmd_type    cmd
);
   import u2a_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, rsp_valid_ff;

   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.dabble = 1'b0;
      cmd.shift  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            // only decimal loads a non-zero step count
            if (status.dabble_done) begin
               state_in = ST_SKIP;
            end else begin
               cmd.dabble = 1'b1;
            end
         end
         ST_SKIP: begin
            // drop leading zeros but always keep one digit
            if (status.top_zero && !status.cnt_one) begin
               cmd.shift = 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               if (status.cnt_one) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.shift = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= (state_in == ST_IDLE);
         rsp_valid_ff <= (state_in == ST_EMIT);
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hw/rtl/u2a_checker.sv =====
// port-level checker for the converter and its bind to the top level
`timescale 1ns / 1ps

module u2a_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input u2a_pkg::rsp_type rsp_payload
);
   import u2a_pkg::*;

   logic [6:0] chr;
   assign chr = rsp_payload.digit_char;

   // a waiting digit holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp transaction dropped or changed while stalled");

   // one value at a time: never taking a request while digits go out
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("req_ready high while a digit is pending");

   // after the last digit the block goes quiet on rsp
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_payload.last_digit |=> !rsp_valid)
      else $error("rsp_valid stayed high after the last digit");

   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid && !req_ready)
      else $error("unexpected handshake state right after a request");

   a_legal_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((chr >= 7'd48) && (chr <= 7'd57)) ||
                    ((chr >= 7'd65) && (chr <= 7'd70)))
      else $error("digit character outside 0-9 and A-F");

endmodule

bind uint_to_ascii_radix u2a_checker u_checker (.*);

// ===== tb/testbench.sv =====
// self-checking testbench for uint_to_ascii_radix: directed table, then randomised values
`timescale 1ns / 1ps

module testbench;
   import u2a_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   rsp_type expected_digits[$];
   string   typed_text = "";
   int      send_idle_pct = 0;
   int      rsp_idle_pct = 0;
   int      mismatch_count = 0;
   int      values_done = 0;
   int      digits_done = 0;
   int      radix_count[4] = '{0, 0, 0, 0};

   logic [63:0] table_value[$];
   logic [1:0]  table_radix[$];
   string       table_text[$];

   uint_to_ascii_radix i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always #6 clock = ~clock;

   // digits of one value, least significant produced first, queued most significant first
   function automatic void queue_radix_digits(input logic [63:0] value, input logic [1:0] sel);
      logic [63:0] rest;
      logic [63:0] base;
      logic [3:0]  d;
      logic [6:0]  rev[64];
      int          count;
      rsp_type     item;
      rest = value & ({64{1'b1}} >> (64 - VALUE_WIDTH));
      case (sel)
         RADIX_BIN: base = 64'd2;
         RADIX_OCT: base = 64'd8;
         RADIX_DEC: base = 64'd10;
         default:   base = 64'd16;
      endcase
      count = 0;
      do begin
         d = 4'(rest % base);
         rev[count] = (d < 4'd10) ? ASCII_ZERO + 7'(d) : ASCII_UPPER_A + 7'(d - 4'd10);
         count++;
         rest = rest / base;
      end while (rest != 64'd0 && count < 64);
      for (int k = count - 1; k >= 0; k--) begin
         item.digit_char = rev[k];
         item.last_digit = (k == 0);
         expected_digits.push_back(item);
      end
   endfunction

   function automatic void queue_text_digits(input string text);
      byte     ch;
      rsp_type item;
      for (int i = 0; i < text.len(); i++) begin
         ch = text[i];
         item.digit_char = ch[6:0];
         item.last_digit = (i == text.len() - 1);
         expected_digits.push_back(item);
      end
   endfunction

   // accepted transactions on both channels
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            if (typed_text != "") begin
               queue_text_digits(typed_text);
            end else begin
               queue_radix_digits(req_payload.value, req_payload.radix_select);
            end
            values_done++;
            radix_count[req_payload.radix_select]++;
         end
         if (rsp_valid && rsp_ready) begin
            digits_done++;
            if (expected_digits.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("unexpected digit: char %0d last %0b",
                           rsp_payload.digit_char, rsp_payload.last_digit);
               end
            end else begin
               want = expected_digits.pop_front();
               if (rsp_payload.digit_char !== want.digit_char ||
                   rsp_payload.last_digit !== want.last_digit) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("digit mismatch: expected char %0d last %0b, got char %0d last %0b",
                              want.digit_char, want.last_digit,
                              rsp_payload.digit_char, rsp_payload.last_digit);
                  end
               end
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_value(input logic [63:0] value, input logic [1:0] sel, input string text);
      req_type item;
      item.value = value;
      item.radix_select = sel;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      typed_text = text;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic drain_digits();
      req_valid <= 1'b0;
      while (expected_digits.size() != 0) @(negedge clock);
   endtask

   function automatic logic [63:0] random_value();
      logic [63:0] v;
      case ($urandom_range(5))
         0: v = 64'($urandom_range(20));
         1: v = {$urandom, $urandom};
         2: v = {$urandom, $urandom} >> $urandom_range(63);
         3: v = {64{1'b1}} >> $urandom_range(63);
         4: v = 64'd1 << $urandom_range(63);
         default: begin
            // decimal boundaries such as 10^k and 10^k - 1
            v = 64'd1;
            repeat ($urandom_range(19)) v = v * 64'd10;
            v = v - 64'($urandom_range(1));
         end
      endcase
      return v;
   endfunction

   task automatic add_row(input logic [63:0] value, input logic [1:0] sel, input string text);
      table_value.push_back(value);
      table_radix.push_back(sel);
      table_text.push_back(text);
   endtask

   initial begin
      add_row(64'd0, RADIX_BIN, "0");
      add_row(64'd0, RADIX_OCT, "0");
      add_row(64'd0, RADIX_DEC, "0");
      add_row(64'd0, RADIX_HEX, "0");
      add_row(64'd1, RADIX_BIN, "1");
      add_row(64'd1, RADIX_OCT, "1");
      add_row(64'd1, RADIX_DEC, "1");
      add_row(64'd1, RADIX_HEX, "1");
      add_row({64{1'b1}}, RADIX_BIN,
              "1111111111111111111111111111111111111111111111111111111111111111");
      add_row({64{1'b1}}, RADIX_OCT, "1777777777777777777777");
      add_row({64{1'b1}}, RADIX_DEC, "18446744073709551615");
      add_row({64{1'b1}}, RADIX_HEX, "FFFFFFFFFFFFFFFF");
      add_row(64'd8, RADIX_OCT, "10");
      add_row(64'd9, RADIX_DEC, "9");
      add_row(64'd10, RADIX_DEC, "10");
      add_row(64'd10, RADIX_HEX, "A");
      add_row(64'd15, RADIX_HEX, "F");
      add_row(64'd255, RADIX_HEX, "FF");
      add_row(64'h8000_0000_0000_0000, RADIX_HEX, "8000000000000000");
      add_row(64'h0123_4567_89AB_CDEF, RADIX_HEX, "123456789ABCDEF");
      add_row(64'd1000000000000000000, RADIX_DEC, "1000000000000000000");
      add_row(64'h8000_0000_0000_0000, RADIX_BIN, "");
      add_row(64'hAAAA_AAAA_AAAA_AAAA, RADIX_BIN, "");
      add_row(64'h5555_5555_5555_5555, RADIX_OCT, "");
      add_row(64'h7FFF_FFFF_FFFF_FFFF, RADIX_DEC, "");

      send_idle_pct = 17;
      rsp_idle_pct = 88;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < table_value.size(); i++) begin
         send_value(table_value[i], table_radix[i], table_text[i]);
      end
      // hold the sender off until the block has emptied
      drain_digits();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 17; rsp_idle_pct = 88; end
            1: begin send_idle_pct = 88; rsp_idle_pct = 17; end
            default: begin send_idle_pct = 0; rsp_idle_pct = 0; end
         endcase
         for (int n = 0; n < 167; n++) begin
            send_value(random_value(), 2'($urandom_range(3)), "");
         end
         drain_digits();
      end

      repeat (150) @(negedge clock);
      $display("%0d values converted (%0d bin, %0d oct, %0d dec, %0d hex), %0d digits checked",
               values_done, radix_count[0], radix_count[1], radix_count[2], radix_count[3],
               digits_done);
      $display("idling: sender light/receiver heavy, then reversed, then none");
      if (mismatch_count == 0) begin
         $display("uint_to_ascii_radix verification clean");
      end else begin
         $display("uint_to_ascii_radix verification failed");
      end
      $finish;
   end

   initial begin
      #30_000_000;
      $display("uint_to_ascii_radix verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/u2a_pkg.sv
hw/rtl/u2a_datapath.sv
hw/rtl/u2a_ctrl.sv
hw/rtl/uint_to_ascii_radix.sv
hw/rtl/u2a_checker.sv
tb/testbench.sv
